// ===== src/cmykt_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the cmyk additive tint pipeline
// no dependencies; imported by every module of the block
package cmykt_pkg;

    localparam int FRACTION_BITS_DEF   = 16;
    localparam int COLOR_W             = 8;
    localparam int NUM_CH              = 3;
    localparam int NUM_LANES           = 2 * NUM_CH;
    localparam int NUMER_W             = 2 * COLOR_W;
    localparam int KM_W                = COLOR_W + 2;
    localparam int DIV_STEPS_PER_STAGE = 4;
    localparam int MAG_EXTRA_W         = 17;
    localparam int VAL_EXTRA_W         = 12;
    localparam int MIX_FIXED_STAGES    = 5;
    localparam int CFG_IDX_W           = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_BLUE  = 2'd2;

    localparam logic [COLOR_W-1:0] CMAX      = 8'd255;
    localparam logic [COLOR_W-1:0] CEIL_BIAS = 8'd254;

    typedef logic [NUM_CH-1:0][COLOR_W-1:0] t_rgb;

    typedef struct packed {
        logic                   valid;
        logic signed [KM_W-1:0] km;
    } t_ctl;

endpackage

// ===== src/cmykt_cvt.sv =====
`timescale 1ns / 1ps
// front stage: max of each color, divider operands and the mixed black term
// depends on cmykt_pkg
module cmykt_cvt import cmykt_pkg::*; (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  t_rgb                                i_base,
    input  t_rgb                                i_pix,
    output t_ctl                                o_ctl,
    output logic [NUM_LANES-1:0][NUMER_W-1:0]   o_numer,
    output logic [NUM_LANES-1:0][COLOR_W-1:0]   o_divisor
);

    function automatic logic [COLOR_W-1:0] max3(input t_rgb c);
        logic [COLOR_W-1:0] m;
        m = c[0];
        if (c[1] > m) m = c[1];
        if (c[2] > m) m = c[2];
        return m;
    endfunction

    logic [COLOR_W-1:0]                   mx_base;
    logic [COLOR_W-1:0]                   mx_pix;
    t_ctl                                 n_ctl;
    t_ctl                                 r_ctl;
    logic [NUM_LANES-1:0][NUMER_W-1:0]    n_numer;
    logic [NUM_LANES-1:0][NUMER_W-1:0]    r_numer;
    logic [NUM_LANES-1:0][COLOR_W-1:0]    n_divisor;
    logic [NUM_LANES-1:0][COLOR_W-1:0]    r_divisor;

    always_comb begin
        logic [COLOR_W-1:0] d;
        d         = '0;
        mx_base   = max3(i_base);
        mx_pix    = max3(i_pix);
        n_ctl.valid = i_valid;
        n_ctl.km    = KM_W'({2'b00, mx_base}) + KM_W'({2'b00, mx_pix}) - KM_W'(CMAX);
        for (int c = 0; c < NUM_CH; c++) begin
            // 255 * d as (d << 8) - d
            d = mx_base - i_base[c];
            n_numer[c]   = {d, COLOR_W'(0)} - NUMER_W'(d);
            n_divisor[c] = (mx_base == '0) ? COLOR_W'(1) : mx_base;
            d = mx_pix - i_pix[c];
            n_numer[c+NUM_CH]   = {d, COLOR_W'(0)} - NUMER_W'(d);
            n_divisor[c+NUM_CH] = (mx_pix == '0) ? COLOR_W'(1) : mx_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= n_ctl.valid;
        end
        r_ctl.km  <= n_ctl.km;
        r_numer   <= n_numer;
        r_divisor <= n_divisor;
    end

    assign o_ctl     = r_ctl;
    assign o_numer   = r_numer;
    assign o_divisor = r_divisor;

endmodule

// ===== src/cmykt_div.sv =====
`timescale 1ns / 1ps
// pipelined restoring divider, six lanes, four quotient bits per stage
// depends on cmykt_pkg
module cmykt_div import cmykt_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  t_ctl                                              i_ctl,
    input  logic [NUM_LANES-1:0][NUMER_W-1:0]                 i_numer,
    input  logic [NUM_LANES-1:0][COLOR_W-1:0]                 i_divisor,
    output t_ctl                                              o_ctl,
    output logic [NUM_LANES-1:0][COLOR_W+FRACTION_BITS-1:0]   o_quot
);

    localparam int QW   = COLOR_W + FRACTION_BITS;
    localparam int NSTG = (QW + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    t_ctl                                 stg_ctl [NSTG+1];
    logic [NUM_LANES-1:0][COLOR_W-1:0]    stg_rem [NSTG+1];
    logic [NUM_LANES-1:0][QW-1:0]         stg_qf  [NSTG+1];
    logic [NUM_LANES-1:0][COLOR_W-1:0]    stg_div [NSTG+1];
    logic [NUM_LANES-1:0][COLOR_W-1:0]    in_rem;
    logic [NUM_LANES-1:0][QW-1:0]         in_qf;

    // upper numerator byte is already below the divisor
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            in_rem[l] = i_numer[l][NUMER_W-1:COLOR_W];
            in_qf[l]  = {i_numer[l][COLOR_W-1:0], FRACTION_BITS'(0)};
        end
    end

    assign stg_ctl[0] = i_ctl;
    assign stg_rem[0] = in_rem;
    assign stg_qf[0]  = in_qf;
    assign stg_div[0] = i_divisor;

    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic [NUM_LANES-1:0][COLOR_W-1:0] n_rem;
        logic [NUM_LANES-1:0][COLOR_W-1:0] r_rem;
        logic [NUM_LANES-1:0][QW-1:0]      n_qf;
        logic [NUM_LANES-1:0][QW-1:0]      r_qf;
        logic [NUM_LANES-1:0][COLOR_W-1:0] r_div;
        t_ctl                              r_ctl;

        always_comb begin
            logic [COLOR_W:0] sh;
            logic             ge;
            sh    = '0;
            ge    = 1'b0;
            n_rem = stg_rem[s];
            n_qf  = stg_qf[s];
            for (int l = 0; l < NUM_LANES; l++) begin
                for (int j = 0; j < DIV_STEPS_PER_STAGE; j++) begin
                    if (s * DIV_STEPS_PER_STAGE + j < QW) begin
                        sh       = {n_rem[l], n_qf[l][QW-1]};
                        ge       = (sh >= {1'b0, stg_div[s][l]});
                        n_rem[l] = ge ? COLOR_W'(sh - {1'b0, stg_div[s][l]})
                                      : sh[COLOR_W-1:0];
                        n_qf[l]  = {n_qf[l][QW-2:0], ge};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl.valid <= 1'b0;
            end else begin
                r_ctl.valid <= stg_ctl[s].valid;
            end
            r_ctl.km <= stg_ctl[s].km;
            r_rem    <= n_rem;
            r_qf     <= n_qf;
            r_div    <= stg_div[s];
        end

        assign stg_ctl[s+1] = r_ctl;
        assign stg_rem[s+1] = r_rem;
        assign stg_qf[s+1]  = r_qf;
        assign stg_div[s+1] = r_div;
    end

    assign o_ctl  = stg_ctl[NSTG];
    assign o_quot = stg_qf[NSTG];

endmodule

// ===== src/cmykt_mix.sv =====
`timescale 1ns / 1ps
// back end: cmy sum, scale by black term, floor divide by 255, clamp to rgb
// depends on cmykt_pkg
module cmykt_mix import cmykt_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  t_ctl                                              i_ctl,
    input  logic [NUM_LANES-1:0][COLOR_W+FRACTION_BITS-1:0]   i_quot,
    output logic                                              o_valid,
    output t_rgb                                              o_rgb
);

    localparam int QW = COLOR_W + FRACTION_BITS;
    localparam int SW = QW + 1;
    localparam int PW = SW + 1 + KM_W;
    localparam int XW = FRACTION_BITS + MAG_EXTRA_W;
    localparam int NS = (XW + COLOR_W - 1) / COLOR_W;
    localparam int VW = FRACTION_BITS + VAL_EXTRA_W;

    // cmy sum
    t_ctl                           r_s_ctl;
    logic [NUM_CH-1:0][SW-1:0]      n_csum;
    logic [NUM_CH-1:0][SW-1:0]      r_csum;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_csum[c] = SW'(i_quot[c]) + SW'(i_quot[c+NUM_CH]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_ctl.valid <= 1'b0;
        end else begin
            r_s_ctl.valid <= i_ctl.valid;
        end
        r_s_ctl.km <= i_ctl.km;
        r_csum     <= n_csum;
    end

    // signed product with (255 - k)
    t_ctl                           r_p_ctl;
    logic [NUM_CH-1:0][PW-1:0]      n_prod;
    logic [NUM_CH-1:0][PW-1:0]      r_prod;

    always_comb begin
        logic signed [PW-1:0] pa;
        logic signed [PW-1:0] pb;
        pa = '0;
        pb = PW'($signed(r_s_ctl.km));
        for (int c = 0; c < NUM_CH; c++) begin
            pa        = PW'($signed({1'b0, r_csum[c]}));
            n_prod[c] = pa * pb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl.valid <= 1'b0;
        end else begin
            r_p_ctl.valid <= r_s_ctl.valid;
        end
        r_p_ctl.km <= r_s_ctl.km;
        r_prod     <= n_prod;
    end

    // magnitude for floor division, negative side biased by 254
    t_ctl                           r_x_ctl;
    logic [NUM_CH-1:0]              n_neg;
    logic [NUM_CH-1:0]              r_neg;
    logic [NUM_CH-1:0][XW-1:0]      n_x;
    logic [NUM_CH-1:0][XW-1:0]      r_x;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_neg[c] = r_prod[c][PW-1];
            n_x[c]   = n_neg[c] ? XW'(PW'(CEIL_BIAS) - r_prod[c]) : XW'(r_prod[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_ctl.valid <= 1'b0;
        end else begin
            r_x_ctl.valid <= r_p_ctl.valid;
        end
        r_x_ctl.km <= r_p_ctl.km;
        r_neg      <= n_neg;
        r_x        <= n_x;
    end

    // divide by 255 one byte digit per stage: x = 255*h + (h + l)
    t_ctl                           stg_ctl [NS+1];
    logic [NUM_CH-1:0]              stg_neg [NS+1];
    logic [NUM_CH-1:0][XW-1:0]      stg_y   [NS+1];
    logic [NUM_CH-1:0][XW-1:0]      stg_q   [NS+1];

    assign stg_ctl[0] = r_x_ctl;
    assign stg_neg[0] = r_neg;
    assign stg_y[0]   = r_x;
    assign stg_q[0]   = '0;

    for (genvar s = 0; s < NS; s++) begin : g_d255
        logic [NUM_CH-1:0][XW-1:0] n_y;
        logic [NUM_CH-1:0][XW-1:0] r_y;
        logic [NUM_CH-1:0][XW-1:0] n_q;
        logic [NUM_CH-1:0][XW-1:0] r_q;
        logic [NUM_CH-1:0]         r_sneg;
        t_ctl                      r_ctl;

        always_comb begin
            for (int c = 0; c < NUM_CH; c++) begin
                n_y[c] = XW'(stg_y[s][c][XW-1:COLOR_W]) + XW'(stg_y[s][c][COLOR_W-1:0]);
                n_q[c] = stg_q[s][c] + XW'(stg_y[s][c][XW-1:COLOR_W]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl.valid <= 1'b0;
            end else begin
                r_ctl.valid <= stg_ctl[s].valid;
            end
            r_ctl.km <= stg_ctl[s].km;
            r_sneg   <= stg_neg[s];
            r_y      <= n_y;
            r_q      <= n_q;
        end

        assign stg_ctl[s+1] = r_ctl;
        assign stg_neg[s+1] = r_sneg;
        assign stg_y[s+1]   = r_y;
        assign stg_q[s+1]   = r_q;
    end

    // last correction of the quotient
    t_ctl                           r_f_ctl;
    logic [NUM_CH-1:0]              r_f_neg;
    logic [NUM_CH-1:0][XW-1:0]      n_fq;
    logic [NUM_CH-1:0][XW-1:0]      r_fq;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            n_fq[c] = stg_q[NS][c] + XW'(stg_y[NS][c] >= XW'(CMAX));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_ctl.valid <= 1'b0;
        end else begin
            r_f_ctl.valid <= stg_ctl[NS].valid;
        end
        r_f_ctl.km <= stg_ctl[NS].km;
        r_f_neg    <= stg_neg[NS];
        r_fq       <= n_fq;
    end

    // v = (255 - k) * one - floor(p / 255), then truncate and clamp
    logic   r_valid;
    t_rgb   n_rgb;
    t_rgb   r_rgb;

    always_comb begin
        logic signed [VW-1:0] kmf;
        logic        [VW-1:0] v;
        kmf = VW'($signed(r_f_ctl.km)) <<< FRACTION_BITS;
        v   = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            v = r_f_neg[c] ? (kmf + VW'(r_fq[c])) : (kmf - VW'(r_fq[c]));
            if (v[VW-1]) begin
                n_rgb[c] = '0;
            end else if (|v[VW-2:FRACTION_BITS+COLOR_W]) begin
                n_rgb[c] = CMAX;
            end else begin
                n_rgb[c] = v[FRACTION_BITS+COLOR_W-1:FRACTION_BITS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_f_ctl.valid;
        end
        r_rgb <= n_rgb;
    end

    assign o_valid = r_valid;
    assign o_rgb   = r_rgb;

endmodule

// ===== src/cmyk_additive_color_tint.sv =====
`timescale 1ns / 1ps
// Tints one RGB color per clock against the base color held in three config
// registers: both colors go to CMYK, the components are summed and converted
// back to RGB with clamping. A new item is taken every cycle (busy stays low)
// and its result shows on o_strobe after the converter, divider and mixer stages;
// the depth is set by the divider, which settles four quotient bits per stage,
// and by the divide-by-255 chain, which folds one byte per stage. The receiver
// cannot stall, so a result is valid for a single cycle only. Config writes
// take effect at once and are meant for idle periods.
// depends on cmykt_pkg, cmykt_cvt, cmykt_div, cmykt_mix
module cmyk_additive_color_tint import cmykt_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [COLOR_W-1:0]     i_cfg_data,
    input  logic [COLOR_W-1:0]     i_in_red,
    input  logic [COLOR_W-1:0]     i_in_green,
    input  logic [COLOR_W-1:0]     i_in_blue,
    output logic                   o_strobe,
    output logic [COLOR_W-1:0]     o_out_red,
    output logic [COLOR_W-1:0]     o_out_green,
    output logic [COLOR_W-1:0]     o_out_blue
);

    localparam int QW      = COLOR_W + FRACTION_BITS;
    localparam int LATENCY = 1 + (QW + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE
                           + MIX_FIXED_STAGES
                           + (FRACTION_BITS + MAG_EXTRA_W + COLOR_W - 1) / COLOR_W;

    t_rgb   r_base;
    t_rgb   n_base;
    t_rgb   pix;
    logic   accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign pix    = {i_in_blue, i_in_green, i_in_red};

    always_comb begin
        n_base = r_base;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BASE_RED:   n_base[0] = i_cfg_data;
                REG_BASE_GREEN: n_base[1] = i_cfg_data;
                REG_BASE_BLUE:  n_base[2] = i_cfg_data;
                default:        n_base    = r_base;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= {NUM_CH{CMAX}};
        end else begin
            r_base <= n_base;
        end
    end

    t_ctl                                   cvt_ctl;
    logic [NUM_LANES-1:0][NUMER_W-1:0]      cvt_numer;
    logic [NUM_LANES-1:0][COLOR_W-1:0]      cvt_divisor;
    t_ctl                                   div_ctl;
    logic [NUM_LANES-1:0][QW-1:0]           div_quot;
    logic                                   mix_valid;
    t_rgb                                   mix_rgb;

    cmykt_cvt u_cvt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (accept),
        .i_base    (r_base),
        .i_pix     (pix),
        .o_ctl     (cvt_ctl),
        .o_numer   (cvt_numer),
        .o_divisor (cvt_divisor)
    );

    cmykt_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (cvt_ctl),
        .i_numer   (cvt_numer),
        .i_divisor (cvt_divisor),
        .o_ctl     (div_ctl),
        .o_quot    (div_quot)
    );

    cmykt_mix #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_quot  (div_quot),
        .o_valid (mix_valid),
        .o_rgb   (mix_rgb)
    );

    assign o_strobe    = mix_valid;
    assign o_out_red   = mix_rgb[0];
    assign o_out_green = mix_rgb[1];
    assign o_out_blue  = mix_rgb[2];

    // every accepted item comes out after the fixed latency
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("accepted item did not produce a result");

    // no result without an item accepted the latency earlier
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LATENCY))
        else $error("result without a matching item");

    // black in stays black out whatever the base color
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in_red == '0 && i_in_green == '0 && i_in_blue == '0)
        |-> ##LATENCY (o_strobe && o_out_red == '0 && o_out_green == '0
                       && o_out_blue == '0))
        else $error("black item gave a non-black result");

endmodule
